// ----- sv/lvrf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvrf_pkg: shared constants and types of the latest version row filter
// Table geometry, field widths, marker codes and register indexes.
// ----------------------------------------------------------------------------
package lvrf_pkg;

	localparam int TABLE_ENTRIES = 1024;
	localparam int KEY_WIDTH     = 64;
	localparam int VER_W         = 64;
	localparam int LATE_W        = 48;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
	localparam int ENTRY_W       = KEY_WIDTH + VER_W;
	localparam int PADDR_W       = 3;

	// item codes
	typedef enum logic [1:0] {
		FUNC_ROW       = 2'd0,
		FUNC_HIST_START = 2'd1,
		FUNC_HIST_END  = 2'd2,
		FUNC_HEARTBEAT = 2'd3
	} func_t;

	// register indexes
	localparam logic REG_EQUAL_PASSES = 1'b0;
	localparam logic REG_BACKFILL_UNIQUE = 1'b1;

endpackage

// ----- sv/latest_version_row_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latest_version_row_filter: per-key latest version filter
// Keeps the newest version of every key and drops rows that arrive late.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_stall) carries one word: func, row_key,
//    row_version. Output channel (out_valid/out_stall) returns one word per
//    input: keep, new_key, table_full, late_total.
//  - Keys live in one RAM; entries fill from index 0 upward and are never
//    freed, so a fill count marks the valid ones. A data row is looked up
//    by a linear scan through the filled entries with one shared key
//    comparator, one entry per cycle.
//  - A marker or heartbeat goes from S_IDLE straight to S_OUT; a data row
//    first scans the filled entries (at most 1024), passing S_UPD on a hit.
//    in_stall stays high until the result enters the output register.
//  - The output register is separate: a new word is accepted while the
//    last result still waits; a stalled result holds until taken.
//  - Reset empties the table (fill count zero), clears the backfill marks,
//    the late counter and both registers. No clearing pass is needed.
//  - User writes registers over APB only while the block is idle (unenforced).
// ----------------------------------------------------------------------------
module latest_version_row_filter
	import lvrf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic [63:0]        row_key,
	input  logic signed [63:0] row_version,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               keep,
	output logic               new_key,
	output logic               table_full,
	output logic [LATE_W-1:0]  late_total
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_UPD  = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t state_q;

	logic                 eq_pass_q, bf_unique_q;
	logic                 seen_start_q, finished_q;
	logic [LATE_W-1:0]    late_q;
	logic [CNT_W-1:0]     fill_q, idx_q;
	logic [IDX_W-1:0]     cmp_idx_q, hit_idx_q;
	logic                 pend_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [VER_W-1:0]     ver_q, hit_ver_q;
	logic                 r_keep_q, r_new_q, r_full_q;
	logic                 out_valid_q, o_keep_q, o_new_q, o_full_q;
	logic [LATE_W-1:0]    o_late_q;

	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr, ram_raddr;
	logic [ENTRY_W-1:0]   ram_wdata, ram_rdata;
	logic                 in_acc, cfg_wr, key_match, backfilling, ver_newer, ver_equal;
	logic                 out_load;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = {31'd0, (paddr[2] == REG_BACKFILL_UNIQUE) ? bf_unique_q : eq_pass_q};

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eq_pass_q   <= 1'b0;
			bf_unique_q <= 1'b0;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_EQUAL_PASSES) begin
				eq_pass_q <= pwdata[0];
			end else begin
				bf_unique_q <= pwdata[0];
			end
		end
	end

	assign in_stall    = (state_q != S_IDLE);
	assign in_acc      = in_valid && !in_stall;
	assign key_match   = pend_q && (ram_rdata[ENTRY_W-1 -: KEY_WIDTH] == key_q);
	assign backfilling = bf_unique_q && seen_start_q && !finished_q;
	assign ver_newer   = $signed(ver_q) > $signed(hit_ver_q);
	assign ver_equal   = (ver_q == hit_ver_q);
	assign out_load    = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	// table RAM access: scan reads, insert or update writes
	assign ram_raddr = idx_q[IDX_W-1:0];
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = hit_idx_q;
		ram_wdata = {key_q, ver_q};
		if (state_q == S_SCAN && !pend_q && idx_q == fill_q
				&& fill_q != CNT_W'(TABLE_ENTRIES)) begin
			ram_we    = 1'b1;
			ram_waddr = fill_q[IDX_W-1:0];
		end else if (state_q == S_UPD && (backfilling || ver_newer)) begin
			ram_we = 1'b1;
		end
	end

	lvrf_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer: scan, decide, hand off to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			seen_start_q <= 1'b0;
			finished_q   <= 1'b0;
			late_q       <= '0;
			fill_q       <= '0;
			idx_q        <= '0;
			pend_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			r_keep_q     <= 1'b0;
			r_new_q      <= 1'b0;
			r_full_q     <= 1'b0;
		end else begin
			// load a new result word or drop the one just taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						r_keep_q <= 1'b0;
						r_new_q  <= 1'b0;
						r_full_q <= 1'b0;
						idx_q    <= '0;
						pend_q   <= 1'b0;
						if (func == FUNC_ROW) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_OUT;
							if (!finished_q) begin
								if (!seen_start_q) begin
									if (func == FUNC_HIST_START) begin
										seen_start_q <= 1'b1;
									end
								end else if (func == FUNC_HIST_END) begin
									finished_q <= 1'b1;
								end
							end
						end
					end
				end
				S_SCAN: begin
					if (key_match) begin
						state_q <= S_UPD;
						pend_q  <= 1'b0;
					end else if (!pend_q && idx_q == fill_q) begin
						// miss: insert at the next free entry or flag full
						r_keep_q <= 1'b1;
						if (fill_q != CNT_W'(TABLE_ENTRIES)) begin
							r_new_q <= 1'b1;
							fill_q  <= fill_q + 1'b1;
						end else begin
							r_full_q <= 1'b1;
						end
						state_q <= S_OUT;
					end else if (idx_q != fill_q) begin
						pend_q <= 1'b1;
						idx_q  <= idx_q + 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
				end
				S_UPD: begin
					if (backfilling || ver_newer || (eq_pass_q && ver_equal)) begin
						r_keep_q <= 1'b1;
					end else if (late_q != '1) begin
						late_q <= late_q + 1'b1;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			key_q <= row_key[KEY_WIDTH-1:0];
			ver_q <= row_version;
		end
		if (state_q == S_SCAN && idx_q != fill_q && !key_match) begin
			cmp_idx_q <= idx_q[IDX_W-1:0];
		end
		if (key_match && state_q == S_SCAN) begin
			hit_idx_q <= cmp_idx_q;
			hit_ver_q <= ram_rdata[VER_W-1:0];
		end
		if (out_load) begin
			o_keep_q <= r_keep_q;
			o_new_q  <= r_new_q;
			o_full_q <= r_full_q;
			o_late_q <= late_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign keep       = o_keep_q;
	assign new_key    = o_new_q;
	assign table_full = o_full_q;
	assign late_total = o_late_q;

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(TABLE_ENTRIES))
		else $error("fill count beyond table size");

	a_new_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!o_new_q || o_keep_q) && !(o_new_q && o_full_q))
		else $error("new key result without keep, or new and full together");

	a_late_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		late_q >= $past(late_q))
		else $error("late counter went down");

	a_fill_only_on_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != $past(fill_q)) |-> $past(state_q == S_SCAN))
		else $error("fill count moved outside a scan");

endmodule

// ----- sv/lvrf_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvrf_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module lvrf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
